/* src/tzr_pkg.sv */
// ----------------------------------------------------------------------------
// tzr_pkg: shared types and constants for the torus z-buffer point renderer
// Opcodes, command and configuration records, state codes, shade ramp.
// ----------------------------------------------------------------------------
`default_nettype none

package tzr_pkg;

    // default frame geometry and depth store width
    localparam int DEF_SCREEN_WIDTH  = 50;
    localparam int DEF_SCREEN_HEIGHT = 25;
    localparam int DEF_DEPTH_BITS    = 16;

    // fixed field widths
    localparam int TRIG_W  = 16;
    localparam int INDEX_W = 11;
    localparam int CHAR_W  = 7;
    localparam int SHADE_W = 4;
    localparam int OOZ_W   = 23;   // reciprocal depth, Q1.22, at most 2^22
    localparam int Z_W     = 42;   // depth in Q28

    localparam logic [CHAR_W-1:0] BLANK_CHAR = 7'd32;  // space

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_PLOT  = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CFG_R_INNER    = 3'd0,
        CFG_R_OUTER    = 3'd1,
        CFG_VIEW_DIST  = 3'd2,
        CFG_PROJ_SCALE = 3'd3,
        CFG_COS_A      = 3'd4,
        CFG_SIN_A      = 3'd5,
        CFG_COS_B      = 3'd6,
        CFG_SIN_B      = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_RDATA,
        ST_MATH,
        ST_DIVWAIT,
        ST_PROJ,
        ST_LOOK,
        ST_UPD
    } t_state;

    typedef struct packed {
        t_op                       op;
        logic signed [TRIG_W-1:0]  cos_theta;
        logic signed [TRIG_W-1:0]  sin_theta;
        logic signed [TRIG_W-1:0]  cos_phi;
        logic signed [TRIG_W-1:0]  sin_phi;
        logic        [INDEX_W-1:0] pixel_index;
    } t_cmd;

    typedef struct packed {
        logic        [5:0]        r_inner;
        logic        [5:0]        r_outer;
        logic        [9:0]        view_distance;
        logic        [7:0]        projection_scale;
        logic signed [TRIG_W-1:0] cos_a;
        logic signed [TRIG_W-1:0] sin_a;
        logic signed [TRIG_W-1:0] cos_b;
        logic signed [TRIG_W-1:0] sin_b;
    } t_cfg;

    // shade code 1..12 to ramp character ".,-~:;=!*#$@"
    function automatic logic [CHAR_W-1:0] ramp_char(input logic [SHADE_W-1:0] shade);
        logic [CHAR_W-1:0] c;
        case (shade)
            4'd1:    c = 7'd46;   // .
            4'd2:    c = 7'd44;   // ,
            4'd3:    c = 7'd45;   // -
            4'd4:    c = 7'd126;  // ~
            4'd5:    c = 7'd58;   // :
            4'd6:    c = 7'd59;   // ;
            4'd7:    c = 7'd61;   // =
            4'd8:    c = 7'd33;   // !
            4'd9:    c = 7'd42;   // *
            4'd10:   c = 7'd35;   // #
            4'd11:   c = 7'd36;   // $
            4'd12:   c = 7'd64;   // @
            default: c = BLANK_CHAR;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* src/tzr_if.sv */
// ----------------------------------------------------------------------------
// tzr_if: item and result channels of the renderer
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface tzr_item_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  opcode;
    logic signed [15:0] cos_theta;
    logic signed [15:0] sin_theta;
    logic signed [15:0] cos_phi;
    logic signed [15:0] sin_phi;
    logic        [10:0] pixel_index;

    modport source (output valid, opcode, cos_theta, sin_theta, cos_phi, sin_phi,
                    pixel_index, input ready);
    modport sink   (input valid, opcode, cos_theta, sin_theta, cos_phi, sin_phi,
                    pixel_index, output ready);
endinterface

interface tzr_result_if;
    logic       valid;
    logic       ready;
    logic [6:0] pixel_char;
    logic       pixel_drawn;

    modport source (output valid, pixel_char, pixel_drawn, input ready);
    modport sink   (input valid, pixel_char, pixel_drawn, output ready);
endinterface

`default_nettype wire

/* src/torus_zbuffer_point_renderer.sv */
// ----------------------------------------------------------------------------
// torus_zbuffer_point_renderer: torus sample renderer with a depth buffer
// Items come in on i_item: opcode 0 clears the frame, 1 plots one torus
// surface sample (Q1.14 cosines and sines of the tube and revolution
// angles), 2 reads the character at pixel_index, 3 is ignored. Only reads
// return a result on o_result (pixel_char, pixel_drawn).
// Configuration (radii, view distance, projection scale, rotation A and B)
// is written through i_cfg_wr_en / i_cfg_index / i_cfg_data. The user
// must write it only while idle; the block does not enforce this. Intake
// queues up to two commands ahead of the executing back end. A plot uses
// the shared multiplier for 25 product steps, those after the near check
// overlapped with the reciprocal divider, then 3 projection steps, a depth
// read and a write; an off-screen or unlit sample skips the write and a
// too-near sample ends at the near check. A read passes through ST_READ
// and ST_RDATA before its result is valid. A clear writes one pixel per
// cycle over all SCREEN_WIDTH*SCREEN_HEIGHT pixels. After reset the same
// sweep runs and i_item.ready stays low until it ends. A stalled o_result
// holds its item; a further read waits while the result register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module torus_zbuffer_point_renderer #(
    parameter int SCREEN_WIDTH  = tzr_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = tzr_pkg::DEF_SCREEN_HEIGHT,
    parameter int DEPTH_BITS    = tzr_pkg::DEF_DEPTH_BITS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    tzr_item_if.sink    i_item,
    tzr_result_if.source o_result,
    input  wire         i_cfg_wr_en,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data
);
    import tzr_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;
    logic cmd_valid, cmd_ready, init_done;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{r_inner:          6'd10,
                       r_outer:          6'd20,
                       view_distance:    10'd150,
                       projection_scale: 8'd46,
                       cos_a:            16'sd16384,
                       sin_a:            16'sd0,
                       cos_b:            16'sd16384,
                       sin_b:            16'sd0};
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_R_INNER:    r_cfg.r_inner          <= i_cfg_data[5:0];
                CFG_R_OUTER:    r_cfg.r_outer          <= i_cfg_data[5:0];
                CFG_VIEW_DIST:  r_cfg.view_distance    <= i_cfg_data[9:0];
                CFG_PROJ_SCALE: r_cfg.projection_scale <= i_cfg_data[7:0];
                CFG_COS_A:      r_cfg.cos_a            <= i_cfg_data;
                CFG_SIN_A:      r_cfg.sin_a            <= i_cfg_data;
                CFG_COS_B:      r_cfg.cos_b            <= i_cfg_data;
                CFG_SIN_B:      r_cfg.sin_b            <= i_cfg_data;
            endcase
        end
    end

    tzr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_init_done (init_done),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_ready (cmd_ready)
    );

    tzr_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .DEPTH_BITS    (DEPTH_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_ready (cmd_ready),
        .o_init_done (init_done),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

/* src/tzr_front.sv */
// ----------------------------------------------------------------------------
// tzr_front: item intake
// Accepts items, drops no-ops, and queues commands in a two-entry FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

module tzr_front (
    input  wire             i_clk,
    input  wire             i_rst_n,
    tzr_item_if.sink        i_item,
    input  wire             i_init_done,
    output logic            o_cmd_valid,
    output tzr_pkg::t_cmd   o_cmd,
    input  wire             i_cmd_ready
);
    import tzr_pkg::*;

    t_cmd       r_fifo [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       accept, push, pop;
    t_op        op;

    assign op           = t_op'(i_item.opcode);
    assign i_item.ready = i_init_done && (r_count != 2'd2);
    assign accept       = i_item.valid && i_item.ready;

    // classify: only clear, plot and read reach the back end
    always_comb begin
        unique case (op)
            OP_CLEAR, OP_PLOT, OP_READ: push = accept;
            default:                    push = 1'b0;
        endcase
    end

    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_fifo[r_rd_ptr];
    assign pop         = o_cmd_valid && i_cmd_ready;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= '{op:          op,
                                  cos_theta:   i_item.cos_theta,
                                  sin_theta:   i_item.sin_theta,
                                  cos_phi:     i_item.cos_phi,
                                  sin_phi:     i_item.sin_phi,
                                  pixel_index: i_item.pixel_index};
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)  r_rd_ptr <= ~r_rd_ptr;
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

/* src/tzr_div.sv */
// ----------------------------------------------------------------------------
// tzr_div: reciprocal depth divider
// Restoring division of 2^50 by the depth, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tzr_div (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    input  wire  signed [tzr_pkg::Z_W-1:0]   i_divisor,
    output logic                             o_done,
    output logic        [tzr_pkg::OOZ_W-1:0] o_quot
);
    import tzr_pkg::*;

    localparam int REM_W = 51;
    localparam int DEN_W = 64;

    logic [REM_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [OOZ_W-1:0] r_quot;
    logic [4:0]       r_cnt;
    logic             r_busy, r_done;
    logic             ge;

    // divisor is at least 2^28, so 23 quotient bits suffice
    assign ge = (DEN_W'(r_rem) >= r_den);

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= REM_W'(1) << 50;
            r_den <= DEN_W'(i_divisor) << (OOZ_W - 1);
        end else if (r_busy) begin
            if (ge) r_rem <= r_rem - r_den[REM_W-1:0];
            r_quot <= {r_quot[OOZ_W-2:0], ge};
            r_den  <= r_den >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= 5'(OOZ_W - 1);
        end else if (r_busy) begin
            if (r_cnt == 5'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_cnt <= r_cnt - 5'd1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

/* src/tzr_back.sv */
// ----------------------------------------------------------------------------
// tzr_back: command execution
// Frame clear sweep, pixel read, and the plot datapath around one shared
// multiplier, the reciprocal divider and the depth and shade memories.
// ----------------------------------------------------------------------------
`default_nettype none

module tzr_back #(
    parameter int SCREEN_WIDTH  = tzr_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = tzr_pkg::DEF_SCREEN_HEIGHT,
    parameter int DEPTH_BITS    = tzr_pkg::DEF_DEPTH_BITS
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  tzr_pkg::t_cfg   i_cfg,
    input  wire             i_cmd_valid,
    input  tzr_pkg::t_cmd   i_cmd,
    output logic            o_cmd_ready,
    output logic            o_init_done,
    tzr_result_if.source    o_result
);
    import tzr_pkg::*;

    localparam int PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW     = $clog2(PIXELS);
    localparam int CW     = OOZ_W + DEPTH_BITS;

    localparam logic [4:0] STEP_NEAR = 5'd17;
    localparam logic [4:0] STEP_LAST = 5'd24;
    localparam logic [4:0] STEP_PEND = 5'd27;

    localparam logic signed [Z_W-1:0] Z_MIN = Z_W'(64'sd268435456);  // 1.0 in Q28
    localparam logic signed [63:0]    RND   = (64'sd1 <<< 36) - 64'sd1;

    t_state r_state, n_state;
    t_cmd   r_cmd;

    logic [4:0]    r_step;
    logic [AW-1:0] r_clr_pos, r_pos;
    logic          r_init_done;

    // datapath registers
    logic signed [23:0] r_cx;
    logic signed [22:0] r_cy;
    logic signed [17:0] r_sasb, r_sacb, r_casb, r_cacb, r_ctsp;
    logic signed [33:0] r_t;
    logic signed [19:0] r_u;
    logic signed [43:0] r_x, r_y;
    logic signed [Z_W-1:0] r_z;
    logic signed [37:0] r_l;
    logic signed [31:0] r_k;
    logic signed [63:0] r_xs, r_ys;

    // memories
    logic [DEPTH_BITS-1:0] r_depth_mem [PIXELS];
    logic [SHADE_W-1:0]    r_shade_mem [PIXELS];
    logic [DEPTH_BITS-1:0] r_rd_depth;
    logic [SHADE_W-1:0]    r_rd_shade;

    // output register
    logic              r_out_valid, r_out_drawn;
    logic [CHAR_W-1:0] r_out_char;

    // control
    logic                  cmd_ready, mul_en, div_start, div_done;
    logic                  rd_en, wr_en;
    logic [AW-1:0]         rd_addr, wr_addr;
    logic [DEPTH_BITS-1:0] wr_depth;
    logic [SHADE_W-1:0]    wr_shade;
    logic [OOZ_W-1:0]      div_quot;

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod;

    logic signed [63:0] xs_adj, ys_adj;
    logic signed [27:0] xp, yp;
    logic               on_screen, lit, near, in_range, hit_nearer, drawn;
    logic [AW-1:0]      look_pos;
    logic [CW-1:0]      ooz_ext, dmax_ext;
    logic [DEPTH_BITS-1:0] sat_d;
    logic [12:0]        level;
    logic [SHADE_W-1:0] new_shade;

    tzr_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_divisor (r_z),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    // ---- decode of plot results ----
    assign near     = (r_z < Z_MIN);
    assign lit      = !r_l[37] && (r_l != 38'sd0);
    assign xs_adj   = r_xs + (r_xs[63] ? RND : 64'sd0);
    assign ys_adj   = r_ys + (r_ys[63] ? RND : 64'sd0);
    assign xp       = 28'(xs_adj >>> 36);
    assign yp       = 28'(ys_adj >>> 36);
    assign on_screen = !xp[27] && (xp[26:0] < 27'(SCREEN_WIDTH))
                    && !yp[27] && (yp[26:0] < 27'(SCREEN_HEIGHT));
    assign look_pos = AW'(xp) + AW'(AW'(yp) * AW'(SCREEN_WIDTH));
    assign in_range = (17'(r_cmd.pixel_index) < 17'(PIXELS));

    // saturate reciprocal depth to the store width
    assign ooz_ext    = CW'(div_quot);
    assign dmax_ext   = CW'({DEPTH_BITS{1'b1}});
    assign sat_d      = (ooz_ext > dmax_ext) ? dmax_ext[DEPTH_BITS-1:0]
                                             : ooz_ext[DEPTH_BITS-1:0];
    assign hit_nearer = (sat_d > r_rd_depth);
    assign level      = 13'(r_l >>> 25);
    assign new_shade  = (level > 13'd11) ? 4'd12 : SHADE_W'(level + 13'd1);

    // ---- shared multiplier operand select ----
    always_comb begin
        case (r_step)
            5'd0:    begin mul_a = 32'(i_cfg.r_inner);  mul_b = 32'(r_cmd.cos_theta); end
            5'd1:    begin mul_a = 32'(i_cfg.r_inner);  mul_b = 32'(r_cmd.sin_theta); end
            5'd2:    begin mul_a = 32'(i_cfg.sin_a);    mul_b = 32'(i_cfg.sin_b);     end
            5'd3:    begin mul_a = 32'(i_cfg.sin_a);    mul_b = 32'(i_cfg.cos_b);     end
            5'd4:    begin mul_a = 32'(i_cfg.cos_a);    mul_b = 32'(i_cfg.sin_b);     end
            5'd5:    begin mul_a = 32'(i_cfg.cos_a);    mul_b = 32'(i_cfg.cos_b);     end
            5'd6:    begin mul_a = 32'(i_cfg.cos_b);    mul_b = 32'(r_cmd.cos_phi);   end
            5'd7:    begin mul_a = 32'(r_sasb);         mul_b = 32'(r_cmd.sin_phi);   end
            5'd8:    begin mul_a = 32'(r_cx);           mul_b = 32'(r_u);             end
            5'd9:    begin mul_a = 32'(r_cy);           mul_b = 32'(r_casb);          end
            5'd10:   begin mul_a = 32'(i_cfg.sin_b);    mul_b = 32'(r_cmd.cos_phi);   end
            5'd11:   begin mul_a = 32'(r_sacb);         mul_b = 32'(r_cmd.sin_phi);   end
            5'd12:   begin mul_a = 32'(r_cx);           mul_b = 32'(r_u);             end
            5'd13:   begin mul_a = 32'(r_cy);           mul_b = 32'(r_cacb);          end
            5'd14:   begin mul_a = 32'(i_cfg.cos_a);    mul_b = 32'(r_cx);            end
            5'd15:   begin mul_a = 32'(r_t);            mul_b = 32'(r_cmd.sin_phi);   end
            5'd16:   begin mul_a = 32'(r_cy);           mul_b = 32'(i_cfg.sin_a);     end
            5'd17:   begin mul_a = 32'(r_cmd.cos_theta); mul_b = 32'(r_cmd.sin_phi);  end
            5'd18:   begin mul_a = 32'(r_cmd.cos_phi);  mul_b = 32'(r_cmd.cos_theta); end
            5'd19:   begin mul_a = 32'(r_t);            mul_b = 32'(i_cfg.sin_b);     end
            5'd20:   begin mul_a = 32'(i_cfg.cos_a);    mul_b = 32'(r_ctsp);          end
            5'd21:   begin mul_a = 32'(i_cfg.sin_a);    mul_b = 32'(r_cmd.sin_theta); end
            5'd22:   begin mul_a = 32'(i_cfg.cos_a);    mul_b = 32'(r_cmd.sin_theta); end
            5'd23:   begin mul_a = 32'(i_cfg.sin_a);    mul_b = 32'(r_ctsp);          end
            5'd24:   begin mul_a = 32'(i_cfg.cos_b);    mul_b = 32'(r_u);             end
            5'd25:   begin mul_a = 32'(i_cfg.projection_scale); mul_b = 32'(div_quot); end
            5'd26:   begin mul_a = r_k;                 mul_b = 32'(r_x >>> 14);      end
            5'd27:   begin mul_a = r_k;                 mul_b = 32'(r_y >>> 14);      end
            default: begin mul_a = 32'sd0;              mul_b = 32'sd0;               end
        endcase
    end

    assign prod = mul_a * mul_b;

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr_pos == AW'(PIXELS - 1)) n_state = ST_IDLE;
            ST_IDLE: begin
                if (i_cmd_valid && cmd_ready) begin
                    unique case (i_cmd.op)
                        OP_CLEAR: n_state = ST_CLEAR;
                        OP_PLOT:  n_state = ST_MATH;
                        OP_READ:  n_state = ST_READ;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_READ:  n_state = ST_RDATA;
            ST_RDATA: n_state = ST_IDLE;
            ST_MATH: begin
                if (r_step == STEP_NEAR && near) n_state = ST_IDLE;
                else if (r_step == STEP_LAST)    n_state = ST_DIVWAIT;
            end
            ST_DIVWAIT: if (div_done) n_state = ST_PROJ;
            ST_PROJ:    if (r_step == STEP_PEND) n_state = ST_LOOK;
            ST_LOOK:    n_state = (on_screen && lit) ? ST_UPD : ST_IDLE;
            ST_UPD:     n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // ---- state outputs ----
    always_comb begin
        cmd_ready = 1'b0;
        mul_en    = 1'b0;
        div_start = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = look_pos;
        wr_en     = 1'b0;
        wr_addr   = r_pos;
        wr_depth  = sat_d;
        wr_shade  = new_shade;
        unique case (r_state)
            ST_CLEAR: begin
                wr_en    = 1'b1;
                wr_addr  = r_clr_pos;
                wr_depth = '0;
                wr_shade = '0;
            end
            ST_IDLE:  cmd_ready = !((i_cmd.op == OP_READ) && r_out_valid);
            ST_READ: begin
                rd_en   = in_range;
                rd_addr = AW'(r_cmd.pixel_index);
            end
            ST_MATH: begin
                mul_en    = 1'b1;
                div_start = (r_step == STEP_NEAR) && !near;
            end
            ST_PROJ:  mul_en = 1'b1;
            ST_LOOK:  rd_en  = on_screen && lit;
            ST_UPD:   wr_en  = hit_nearer;
            default:  ;
        endcase
    end

    assign o_cmd_ready = cmd_ready;
    assign o_init_done = r_init_done;

    // ---- control registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_pos   <= '0;
            r_step      <= 5'd0;
            r_init_done <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE && i_cmd_valid && cmd_ready) begin
                r_step    <= 5'd0;
                r_clr_pos <= '0;
            end
            if (r_state == ST_CLEAR) begin
                r_clr_pos <= r_clr_pos + AW'(1);
                if (n_state == ST_IDLE) r_init_done <= 1'b1;
            end
            if (mul_en) r_step <= r_step + 5'd1;
            if (o_result.ready) r_out_valid <= 1'b0;
            if (r_state == ST_RDATA) r_out_valid <= 1'b1;
        end
    end

    // ---- payload registers ----
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_cmd_valid && cmd_ready) r_cmd <= i_cmd;
        if (r_state == ST_LOOK) r_pos <= look_pos;
        if (r_state == ST_RDATA) begin
            r_out_char  <= drawn ? ramp_char(r_rd_shade) : BLANK_CHAR;
            r_out_drawn <= drawn;
        end
    end

    assign drawn = in_range && (r_rd_shade >= 4'd1) && (r_rd_shade <= 4'd12);

    // ---- plot datapath: one product per step ----
    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            case (r_step)
                5'd0:  r_cx   <= 24'(prod + (64'(i_cfg.r_outer) << 14));
                5'd1:  r_cy   <= 23'(prod);
                5'd2:  r_sasb <= 18'(prod >>> 14);
                5'd3:  r_sacb <= 18'(prod >>> 14);
                5'd4:  r_casb <= 18'(prod >>> 14);
                5'd5:  r_cacb <= 18'(prod >>> 14);
                5'd6:  r_t    <= 34'(prod);
                5'd7:  r_u    <= 20'((64'(r_t) + prod) >>> 14);
                5'd8:  r_x    <= 44'(prod);
                5'd9:  r_x    <= 44'(64'(r_x) - prod);
                5'd10: r_t    <= 34'(prod);
                5'd11: r_u    <= 20'((64'(r_t) - prod) >>> 14);
                5'd12: r_y    <= 44'(prod);
                5'd13: r_y    <= 44'(64'(r_y) + prod);
                5'd14: r_t    <= 34'(prod >>> 14);
                5'd15: r_z    <= Z_W'(prod + (64'(i_cfg.view_distance) << 28));
                5'd16: r_z    <= Z_W'(64'(r_z) + prod);
                5'd17: r_ctsp <= 18'(prod >>> 14);
                5'd18: r_t    <= 34'(prod >>> 14);
                5'd19: r_l    <= 38'(prod);
                5'd20: r_l    <= 38'(64'(r_l) - prod);
                5'd21: r_l    <= 38'(64'(r_l) - prod);
                5'd22: r_t    <= 34'(prod);
                5'd23: r_u    <= 20'((64'(r_t) - prod) >>> 14);
                5'd24: r_l    <= 38'(64'(r_l) + prod);
                5'd25: r_k    <= 32'(prod);
                5'd26: r_xs   <= prod + (64'(SCREEN_WIDTH / 2) << 36);
                5'd27: r_ys   <= (64'(SCREEN_HEIGHT / 2) << 36) - prod;
                default: ;
            endcase
        end
    end

    // ---- depth and shade memories ----
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_depth_mem[wr_addr] <= wr_depth;
            r_shade_mem[wr_addr] <= wr_shade;
        end
        if (rd_en) begin
            r_rd_depth <= r_depth_mem[rd_addr];
            r_rd_shade <= r_shade_mem[rd_addr];
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.pixel_char  = r_out_char;
    assign o_result.pixel_drawn = r_out_drawn;

endmodule

`default_nettype wire

/* dv/torus_zbuffer_point_renderer_test.sv */
// ----------------------------------------------------------------------------
// torus_zbuffer_point_renderer_test: self-checking bench for the renderer
// Drives clear, plot, read and no-op items through the valid/ready item
// channel under several register settings, keeps its own copy of the depth
// and shade frames, and checks every pixel read against the predicted frame.
// ----------------------------------------------------------------------------
`default_nettype none

module torus_zbuffer_point_renderer_test;
    timeunit 1ns;
    timeprecision 1ps;
    import tzr_pkg::*;

    localparam int W      = DEF_SCREEN_WIDTH;
    localparam int H      = DEF_SCREEN_HEIGHT;
    localparam int PIXELS = W * H;
    localparam int DBITS  = DEF_DEPTH_BITS;
    localparam int SETTLE = 4000;   // covers three queued clears

    typedef struct {
        logic [6:0] pixel_char;
        logic       pixel_drawn;
    } t_pixel_exp;

    // frame predictor and store of pending read results
    class frame_scoreboard;
        t_cfg              cfg;
        logic [DBITS-1:0]  depth_mem[PIXELS];
        logic [3:0]        shade_mem[PIXELS];
        t_pixel_exp        pending_reads[$];
        int                lit_pixels[$];
        int                errors;

        function new();
            cfg.r_inner          = 6'd10;
            cfg.r_outer          = 6'd20;
            cfg.view_distance    = 10'd150;
            cfg.projection_scale = 8'd46;
            cfg.cos_a            = 16'sd16384;
            cfg.sin_a            = 16'sd0;
            cfg.cos_b            = 16'sd16384;
            cfg.sin_b            = 16'sd0;
            errors = 0;
            blank_frame();
        endfunction

        function void blank_frame();
            for (int i = 0; i < PIXELS; i++) begin
                depth_mem[i] = '0;
                shade_mem[i] = '0;
            end
            lit_pixels.delete();
        endfunction

        function void write_reg(t_cfg_idx idx, logic [15:0] v);
            case (idx)
                CFG_R_INNER:    cfg.r_inner          = v[5:0];
                CFG_R_OUTER:    cfg.r_outer          = v[5:0];
                CFG_VIEW_DIST:  cfg.view_distance    = v[9:0];
                CFG_PROJ_SCALE: cfg.projection_scale = v[7:0];
                CFG_COS_A:      cfg.cos_a            = v;
                CFG_SIN_A:      cfg.sin_a            = v;
                CFG_COS_B:      cfg.cos_b            = v;
                CFG_SIN_B:      cfg.sin_b            = v;
                default: ;
            endcase
        endfunction

        // shift right rounding toward zero
        function longint shr_trunc(longint v, int s);
            if (v >= 0) return v >>> s;
            return -((-v) >>> s);
        endfunction

        function void plot_sample(t_cmd c);
            longint ct, st, cp, sp, ca, sa, cb, sb;
            longint cx, cy, sasb, sacb, casb, cacb, x28, y28, z28;
            longint ooz, k, xs, ys, xp, yp, ctsp, l28, lvl, d;
            int pos;
            ct = longint'($signed(c.cos_theta));
            st = longint'($signed(c.sin_theta));
            cp = longint'($signed(c.cos_phi));
            sp = longint'($signed(c.sin_phi));
            ca = longint'($signed(cfg.cos_a));
            sa = longint'($signed(cfg.sin_a));
            cb = longint'($signed(cfg.cos_b));
            sb = longint'($signed(cfg.sin_b));
            cx = longint'(cfg.r_outer) * 16384 + longint'(cfg.r_inner) * ct;
            cy = longint'(cfg.r_inner) * st;
            sasb = (sa * sb) >>> 14;
            sacb = (sa * cb) >>> 14;
            casb = (ca * sb) >>> 14;
            cacb = (ca * cb) >>> 14;
            x28 = cx * ((cb * cp + sasb * sp) >>> 14) - cy * casb;
            y28 = cx * ((sb * cp - sacb * sp) >>> 14) + cy * cacb;
            z28 = longint'(cfg.view_distance) * (longint'(1) << 28)
                  + ((ca * cx) >>> 14) * sp + cy * sa;
            // near sample or behind the viewer
            if (z28 < (longint'(1) << 28)) return;
            ooz = (longint'(1) << 50) / z28;
            k   = longint'(cfg.projection_scale) * ooz;
            xs  = longint'(W / 2) * (longint'(1) << 36) + k * (x28 >>> 14);
            ys  = longint'(H / 2) * (longint'(1) << 36) - k * (y28 >>> 14);
            xp  = shr_trunc(xs, 36);
            yp  = shr_trunc(ys, 36);
            if (xp < 0 || xp >= W || yp < 0 || yp >= H) return;
            pos  = int'(xp + W * yp);
            ctsp = (ct * sp) >>> 14;
            l28  = ((cp * ct) >>> 14) * sb - ca * ctsp - sa * st
                   + cb * ((ca * st - sa * ctsp) >>> 14);
            if (l28 <= 0) return;
            d = ooz;
            if (d > (longint'(1) << DBITS) - 1) d = (longint'(1) << DBITS) - 1;
            if (d <= longint'(depth_mem[pos])) return;
            depth_mem[pos] = d[DBITS-1:0];
            lvl = (l28 * 8) >>> 28;
            if (lvl > 11) lvl = 11;
            shade_mem[pos] = 4'(lvl + 1);
            lit_pixels.push_back(pos);
            if (lit_pixels.size() > 64) void'(lit_pixels.pop_front());
        endfunction

        // accepted item
        function void note_item(t_cmd c);
            string ramp;
            t_pixel_exp e;
            ramp = ".,-~:;=!*#$@";
            case (c.op)
                OP_CLEAR: blank_frame();
                OP_PLOT:  plot_sample(c);
                OP_READ: begin
                    e.pixel_char  = BLANK_CHAR;
                    e.pixel_drawn = 1'b0;
                    if (c.pixel_index < PIXELS && shade_mem[c.pixel_index] >= 1
                        && shade_mem[c.pixel_index] <= 12) begin
                        e.pixel_char  = 7'(ramp[shade_mem[c.pixel_index] - 1]);
                        e.pixel_drawn = 1'b1;
                    end
                    pending_reads.push_back(e);
                end
                default: ;
            endcase
        endfunction

        // accepted result
        function void check_result(logic [6:0] ch, logic drawn);
            t_pixel_exp e;
            if (pending_reads.size() == 0) begin
                $error("unexpected result: pixel_char %0d pixel_drawn %0d", ch, drawn);
                errors++;
                return;
            end
            e = pending_reads.pop_front();
            if (ch !== e.pixel_char) begin
                $error("pixel_char: expected %0d actual %0d", e.pixel_char, ch);
                errors++;
            end
            if (drawn !== e.pixel_drawn) begin
                $error("pixel_drawn: expected %0d actual %0d", e.pixel_drawn, drawn);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    bit          calm;           // no idling on either side while set

    tzr_item_if   item_ch();
    tzr_result_if result_ch();

    frame_scoreboard frame_sb = new();

    torus_zbuffer_point_renderer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_ch.sink),
        .o_result    (result_ch.source),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // send one item and wait for its handshake
    task automatic send_item(t_cmd c);
        item_ch.valid       <= 1'b1;
        item_ch.opcode      <= c.op;
        item_ch.cos_theta   <= c.cos_theta;
        item_ch.sin_theta   <= c.sin_theta;
        item_ch.cos_phi     <= c.cos_phi;
        item_ch.sin_phi     <= c.sin_phi;
        item_ch.pixel_index <= c.pixel_index;
        do @(posedge i_clk); while (!item_ch.ready);
        frame_sb.note_item(c);
        if (!calm && $urandom_range(0, 99) < 10) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        frame_sb.write_reg(idx, v);
    endtask

    // drain pending reads and let queued clears and plots finish
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        @(posedge i_clk);
        while (frame_sb.pending_reads.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [15:0] q14(real a, bit cosine);
        real v;
        v = cosine ? $cos(a) : $sin(a);
        return 16'(int'(v * 16384.0));
    endfunction

    // item with every field random, opcode as given
    function automatic t_cmd noise_item(t_op op);
        t_cmd c;
        c.op          = op;
        c.cos_theta   = 16'($urandom_range(0, 65535));
        c.sin_theta   = 16'($urandom_range(0, 65535));
        c.cos_phi     = 16'($urandom_range(0, 65535));
        c.sin_phi     = 16'($urandom_range(0, 65535));
        c.pixel_index = 11'($urandom_range(0, 2047));
        return c;
    endfunction

    // torus surface sample, mostly on the unit circle
    function automatic t_cmd plot_item();
        t_cmd c;
        real th, ph;
        c  = noise_item(OP_PLOT);
        th = $urandom_range(0, 62831) / 10000.0;
        ph = $urandom_range(0, 62831) / 10000.0;
        if ($urandom_range(0, 99) < 92) begin
            c.cos_theta = q14(th, 1);
            c.sin_theta = q14(th, 0);
            c.cos_phi   = q14(ph, 1);
            c.sin_phi   = q14(ph, 0);
        end
        return c;
    endfunction

    function automatic t_cmd read_item();
        t_cmd c;
        int r;
        c = noise_item(OP_READ);
        r = $urandom_range(0, 99);
        if (r < 65 && frame_sb.lit_pixels.size() != 0)
            c.pixel_index = 11'(frame_sb.lit_pixels[
                $urandom_range(0, frame_sb.lit_pixels.size() - 1)]);
        else if (r < 90)
            c.pixel_index = 11'($urandom_range(0, PIXELS - 1));
        return c;
    endfunction

    task automatic random_items(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            calm = (i >= n / 3 && i < n / 3 + 60);
            r = $urandom_range(0, 99);
            if (i == 0 || r < 3) send_item(noise_item(OP_CLEAR));
            else if (r < 58)     send_item(plot_item());
            else if (r < 96)     send_item(read_item());
            else                 send_item(noise_item(OP_NOP));
        end
        calm = 1'b0;
    endtask

    // rotation registers from random angles
    task automatic random_rotation();
        real a, b;
        a = $urandom_range(0, 62831) / 10000.0;
        b = $urandom_range(0, 62831) / 10000.0;
        write_reg(CFG_COS_A, q14(a, 1));
        write_reg(CFG_SIN_A, q14(a, 0));
        write_reg(CFG_COS_B, q14(b, 1));
        write_reg(CFG_SIN_B, q14(b, 0));
    endtask

    task automatic directed_items();
        t_cmd c;
        send_item(noise_item(OP_CLEAR));
        c = noise_item(OP_READ); c.pixel_index = 11'd0;       send_item(c);
        c = noise_item(OP_READ); c.pixel_index = 11'(PIXELS - 1); send_item(c);
        // reads out of range
        c = noise_item(OP_READ); c.pixel_index = 11'(PIXELS); send_item(c);
        c = noise_item(OP_READ); c.pixel_index = 11'h7FF;     send_item(c);
        send_item(noise_item(OP_NOP));
        // trig extremes
        c = noise_item(OP_PLOT);
        c.cos_theta = 16'sd16384; c.sin_theta = 16'sd0;
        c.cos_phi = 16'sd16384; c.sin_phi = 16'sd0;           send_item(c);
        c.cos_theta = -16'sd16384; c.cos_phi = -16'sd16384;   send_item(c);
        c.cos_theta = 16'sd0; c.sin_theta = 16'sd16384;
        c.cos_phi = 16'sd0; c.sin_phi = 16'sd16384;           send_item(c);
        c.sin_theta = -16'sd16384; c.sin_phi = -16'sd16384;   send_item(c);
        // beyond unit: level and depth saturation
        c.cos_theta = 16'sh7FFF; c.sin_theta = 16'sh8000;
        c.cos_phi = 16'sh7FFF; c.sin_phi = 16'sh8000;         send_item(c);
        c.cos_theta = 16'sh8000; c.sin_theta = 16'sh7FFF;
        c.cos_phi = 16'sh8000; c.sin_phi = 16'sh7FFF;         send_item(c);
        // same sample twice: second is not nearer
        c = plot_item(); send_item(c); send_item(c);
        for (int i = 0; i < 6; i++) send_item(read_item());
        send_item(noise_item(OP_CLEAR));
        send_item(read_item());
        send_item(read_item());
    endtask

    // result side: check accepted results, stall at random
    initial begin
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && result_ch.valid && result_ch.ready)
                frame_sb.check_result(result_ch.pixel_char, result_ch.pixel_drawn);
            result_ch.ready <= calm || ($urandom_range(0, 99) >= 10);
        end
    end

    // run limit
    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int ri, ro;
        i_rst_n             <= 1'b0;
        i_cfg_wr_en         <= 1'b0;
        i_cfg_index         <= CFG_R_INNER;
        i_cfg_data          <= '0;
        item_ch.valid       <= 1'b0;
        item_ch.opcode      <= OP_NOP;
        item_ch.cos_theta   <= '0;
        item_ch.sin_theta   <= '0;
        item_ch.cos_phi     <= '0;
        item_ch.sin_phi     <= '0;
        item_ch.pixel_index <= '0;
        calm = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values
        directed_items();
        random_items(200);
        wait_idle();

        // low extremes
        write_reg(CFG_R_INNER, 16'd0);
        write_reg(CFG_R_OUTER, 16'd0);
        write_reg(CFG_VIEW_DIST, 16'd64);
        write_reg(CFG_PROJ_SCALE, 16'd0);
        write_reg(CFG_COS_A, -16'sd16384);
        write_reg(CFG_SIN_A, -16'sd16384);
        write_reg(CFG_COS_B, -16'sd16384);
        write_reg(CFG_SIN_B, -16'sd16384);
        wait_idle();
        random_items(200);
        wait_idle();

        // high extremes
        write_reg(CFG_R_INNER, 16'd63);
        write_reg(CFG_R_OUTER, 16'd63);
        write_reg(CFG_VIEW_DIST, 16'd1023);
        write_reg(CFG_PROJ_SCALE, 16'd255);
        write_reg(CFG_COS_A, 16'sd16384);
        write_reg(CFG_SIN_A, 16'sd16384);
        write_reg(CFG_COS_B, 16'sd16384);
        write_reg(CFG_SIN_B, 16'sd16384);
        wait_idle();
        random_items(220);
        wait_idle();

        // torus reaching the viewer: near samples dropped
        write_reg(CFG_VIEW_DIST, 16'd64);
        write_reg(CFG_PROJ_SCALE, 16'd40);
        random_rotation();
        wait_idle();
        random_items(220);
        wait_idle();

        // random sized and rotated tori with a random projection scale
        for (int p = 0; p < 5; p++) begin
            ri = $urandom_range(1, 63);
            ro = $urandom_range(0, 63);
            write_reg(CFG_R_INNER, 16'(ri));
            write_reg(CFG_R_OUTER, 16'(ro));
            write_reg(CFG_VIEW_DIST, 16'($urandom_range(ri + ro + 1, 1023) % 1024 | 64));
            write_reg(CFG_PROJ_SCALE, 16'($urandom_range(0, 255)));
            random_rotation();
            wait_idle();
            random_items(200);
            wait_idle();
        end

        if (frame_sb.errors == 0 && frame_sb.pending_reads.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            if (frame_sb.pending_reads.size() != 0)
                $error("%0d read results never arrived", frame_sb.pending_reads.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* torus_zbuffer_point_renderer.f */
src/tzr_pkg.sv
src/tzr_if.sv
src/tzr_front.sv
src/tzr_div.sv
src/tzr_back.sv
src/torus_zbuffer_point_renderer.sv
dv/torus_zbuffer_point_renderer_test.sv
